/* hdl/gtg_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package gtg_pkg;

   // Field widths of the channels and registers.
   localparam int COORD_W    = 24;
   localparam int HEAD_W     = 20;
   localparam int HTOL_W     = 19;
   localparam int GTOL_W     = 23;
   localparam int ACT_W      = 2;
   localparam int SPEED_W    = 24;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 24;

   // Internal datapath widths.
   localparam int OFS_W   = COORD_W + 1;   // goal minus pose
   localparam int GUARD   = 8;             // extra fraction bits in the rotator
   localparam int VEC_W   = 36;            // rotator x and y
   localparam int ANG_W   = 28;            // rotator angle, Q.24
   localparam int ERR_W   = HEAD_W + 1;    // bearing minus heading
   localparam int ATAN_N  = 24;            // entries of the arctangent table
   localparam int SPLIT   = 17;            // half of the magnitude for the gain multiply
   localparam int GAIN_W  = 30;
   localparam int PROD_W  = SPLIT + GAIN_W;
   localparam int SUM_W   = PROD_W + SPLIT + 1;
   localparam int DIST_SH = 38;
   localparam int DIST_W  = SUM_W - DIST_SH;

   // Action codes.
   localparam logic [ACT_W-1:0] ACT_WAIT    = 2'd0;
   localparam logic [ACT_W-1:0] ACT_REACHED = 2'd1;
   localparam logic [ACT_W-1:0] ACT_TURN    = 2'd2;
   localparam logic [ACT_W-1:0] ACT_FORWARD = 2'd3;

   // Register indexes.
   localparam logic [CSR_IDX_W-1:0] REG_GOAL_X   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_GOAL_Y   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_HEAD_TOL = 2'd2;
   localparam logic [CSR_IDX_W-1:0] REG_GOAL_TOL = 2'd3;

   // Register reset values.
   localparam logic [HTOL_W-1:0] HTOL_RESET = 19'd3277;
   localparam logic [GTOL_W-1:0] GTOL_RESET = 23'd13107;

   // Angle and gain constants.
   localparam logic signed [ANG_W-1:0] PI_Q24       = 28'sd52707179;
   localparam logic signed [ERR_W-1:0] PI_Q16       = 21'sd205887;
   localparam logic signed [ERR_W-1:0] TWO_PI_Q16   = 21'sd411775;
   localparam logic [GAIN_W-1:0]       INV_GAIN_Q30 = 30'd652032874;
   localparam logic [SPEED_W-1:0]      SPEED_MAX    = 24'hFFFFFF;
   localparam logic [SUM_W-1:0]        DIST_ROUND   = 65'h20_0000_0000;

   // Vector held by each rotator stage.
   typedef struct packed {
      logic signed [VEC_W-1:0] x;
      logic signed [VEC_W-1:0] y;
      logic signed [ANG_W-1:0] z;
   } vec_type;

   // Decision flags and heading that ride alongside the vector.
   typedef struct packed {
      logic                     moving;
      logic                     reached;
      logic                     zero;
      logic signed [HEAD_W-1:0] heading;
   } side_type;

   // Arctangent of 2^-idx in Q.24, rounded to nearest.
   function automatic logic signed [ANG_W-1:0] atan_q24(input int unsigned idx);
      case (idx)
         0:  return 28'sd13176795;
         1:  return 28'sd7778716;
         2:  return 28'sd4110060;
         3:  return 28'sd2086331;
         4:  return 28'sd1047214;
         5:  return 28'sd524117;
         6:  return 28'sd262123;
         7:  return 28'sd131069;
         8:  return 28'sd65536;
         9:  return 28'sd32768;
         10: return 28'sd16384;
         11: return 28'sd8192;
         12: return 28'sd4096;
         13: return 28'sd2048;
         14: return 28'sd1024;
         15: return 28'sd512;
         16: return 28'sd256;
         17: return 28'sd128;
         18: return 28'sd64;
         19: return 28'sd32;
         20: return 28'sd16;
         21: return 28'sd8;
         22: return 28'sd4;
         23: return 28'sd2;
         default: return '0;
      endcase
   endfunction

endpackage

`default_nettype wire

/* hdl/gtg_if.sv */
`timescale 1ns / 1ps
`default_nettype none

// Pose sample channel.
interface gtg_req_if import gtg_pkg::*; ();
   logic                      valid;
   logic                      ready;
   logic signed [COORD_W-1:0] pose_x;
   logic signed [COORD_W-1:0] pose_y;
   logic signed [HEAD_W-1:0]  heading;
   logic signed [COORD_W-1:0] lin_vel;
   logic signed [COORD_W-1:0] ang_vel;

   modport source (output valid, pose_x, pose_y, heading, lin_vel,
                   ang_vel, input ready);
   modport sink (input valid, pose_x, pose_y, heading, lin_vel,
                 ang_vel, output ready);
endinterface

// Drive command channel.
interface gtg_rsp_if import gtg_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic [ACT_W-1:0]         action;
   logic signed [HEAD_W-1:0] turn_rate;
   logic [SPEED_W-1:0]       forward_speed;

   modport source (output valid, action, turn_rate, forward_speed, input ready);
   modport sink (input valid, action, turn_rate, forward_speed, output ready);
endinterface

// Register write channel.
interface gtg_csr_if import gtg_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

/* hdl/gtg_front.sv */
`timescale 1ns / 1ps
`default_nettype none

module gtg_front import gtg_pkg::*; (
   input  wire                       clock,
   input  wire                       reset,
   input  wire                       adv,
   input  wire                       in_valid,
   input  wire  signed [COORD_W-1:0] pose_x,
   input  wire  signed [COORD_W-1:0] pose_y,
   input  wire  signed [HEAD_W-1:0]  heading,
   input  wire  signed [COORD_W-1:0] lin_vel,
   input  wire  signed [COORD_W-1:0] ang_vel,
   input  wire  signed [COORD_W-1:0] goal_x,
   input  wire  signed [COORD_W-1:0] goal_y,
   input  wire         [GTOL_W-1:0]  goal_tol,
   output logic                      out_valid,
   output vec_type                   out_vec,
   output side_type                  out_side
);

   logic                     v1_ff;
   logic signed [OFS_W-1:0]  dx_ff, dx_in;
   logic signed [OFS_W-1:0]  dy_ff, dy_in;
   logic                     mov_ff, mov_in;
   logic signed [HEAD_W-1:0] hd_ff;

   logic                     v2_ff;
   vec_type                  vec_ff, vec_in;
   side_type                 side_ff, side_in;

   logic [OFS_W-1:0]         abs_dx, abs_dy;
   logic signed [OFS_W-1:0]  xs, ys;
   logic                     neg;

   // First stage: offsets to the goal and the motion test.
   assign dx_in  = $signed({goal_x[COORD_W-1], goal_x}) - $signed({pose_x[COORD_W-1], pose_x});
   assign dy_in  = $signed({goal_y[COORD_W-1], goal_y}) - $signed({pose_y[COORD_W-1], pose_y});
   assign mov_in = (lin_vel != '0) || (ang_vel != '0);

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else if (adv) begin
         v1_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         dx_ff  <= dx_in;
         dy_ff  <= dy_in;
         mov_ff <= mov_in;
         hd_ff  <= heading;
      end
   end

   // Second stage: tolerance test and the half-plane fold ahead of the rotator.
   assign abs_dx = dx_ff[OFS_W-1] ? OFS_W'(-dx_ff) : OFS_W'(dx_ff);
   assign abs_dy = dy_ff[OFS_W-1] ? OFS_W'(-dy_ff) : OFS_W'(dy_ff);
   assign neg    = dx_ff[OFS_W-1];
   assign xs     = neg ? -dx_ff : dx_ff;
   assign ys     = neg ? -dy_ff : dy_ff;

   always_comb begin
      side_in.moving  = mov_ff;
      side_in.reached = (abs_dx < {{(OFS_W-GTOL_W){1'b0}}, goal_tol})
                        && (abs_dy < {{(OFS_W-GTOL_W){1'b0}}, goal_tol});
      side_in.zero    = (dx_ff == '0) && (dy_ff == '0);
      side_in.heading = hd_ff;
      vec_in.x = {{(VEC_W-OFS_W-GUARD){xs[OFS_W-1]}}, xs, {GUARD{1'b0}}};
      vec_in.y = {{(VEC_W-OFS_W-GUARD){ys[OFS_W-1]}}, ys, {GUARD{1'b0}}};
      if (!neg) begin
         vec_in.z = '0;
      end else if (dy_ff[OFS_W-1]) begin
         vec_in.z = -PI_Q24;
      end else begin
         vec_in.z = PI_Q24;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else if (adv) begin
         v2_ff <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         vec_ff  <= vec_in;
         side_ff <= side_in;
      end
   end

   assign out_valid = v2_ff;
   assign out_vec   = vec_ff;
   assign out_side  = side_ff;

endmodule

`default_nettype wire

/* hdl/gtg_cordic.sv */
`timescale 1ns / 1ps
`default_nettype none

module gtg_cordic import gtg_pkg::*; #(
   parameter int N_STAGES = 16
) (
   input  wire        clock,
   input  wire        reset,
   input  wire        adv,
   input  wire        in_valid,
   input  vec_type    in_vec,
   input  side_type   in_side,
   output logic       out_valid,
   output vec_type    out_vec,
   output side_type   out_side
);

   logic     v_ff    [N_STAGES];
   vec_type  vec_ff  [N_STAGES];
   vec_type  vec_in  [N_STAGES];
   side_type side_ff [N_STAGES];
   vec_type  stage_vec  [N_STAGES];
   side_type stage_side [N_STAGES];
   logic     stage_v    [N_STAGES];

   // One micro-rotation per register stage, driving y towards zero.
   for (genvar i = 0; i < N_STAGES; i++) begin : g_stage
      if (i == 0) begin : g_first
         assign stage_vec[i]  = in_vec;
         assign stage_side[i] = in_side;
         assign stage_v[i]    = in_valid;
      end else begin : g_next
         assign stage_vec[i]  = vec_ff[i-1];
         assign stage_side[i] = side_ff[i-1];
         assign stage_v[i]    = v_ff[i-1];
      end

      always_comb begin
         if (stage_vec[i].y >= 0) begin
            vec_in[i].x = stage_vec[i].x + (stage_vec[i].y >>> i);
            vec_in[i].y = stage_vec[i].y - (stage_vec[i].x >>> i);
            vec_in[i].z = stage_vec[i].z + atan_q24(i);
         end else begin
            vec_in[i].x = stage_vec[i].x - (stage_vec[i].y >>> i);
            vec_in[i].y = stage_vec[i].y + (stage_vec[i].x >>> i);
            vec_in[i].z = stage_vec[i].z - atan_q24(i);
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[i] <= 1'b0;
         end else if (adv) begin
            v_ff[i] <= stage_v[i];
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            vec_ff[i]  <= vec_in[i];
            side_ff[i] <= stage_side[i];
         end
      end
   end

   assign out_valid = v_ff[N_STAGES-1];
   assign out_vec   = vec_ff[N_STAGES-1];
   assign out_side  = side_ff[N_STAGES-1];

endmodule

`default_nettype wire

/* hdl/gtg_back.sv */
`timescale 1ns / 1ps
`default_nettype none

module gtg_back import gtg_pkg::*; (
   input  wire                      clock,
   input  wire                      reset,
   input  wire                      adv,
   input  wire                      in_valid,
   input  vec_type                  in_vec,
   input  side_type                 in_side,
   input  wire         [HTOL_W-1:0] heading_tol,
   input  wire                      rsp_ready,
   output logic                     stage_valid,
   output logic                     rsp_valid,
   output logic        [ACT_W-1:0]  rsp_action,
   output logic signed [HEAD_W-1:0] rsp_turn_rate,
   output logic        [SPEED_W-1:0] rsp_forward_speed
);

   logic signed [ANG_W-1:0]  z_round;
   logic signed [HEAD_W-1:0] bearing;
   logic [2*SPLIT-1:0]       x_mag;

   logic                     v_ff;
   logic signed [ERR_W-1:0]  err_ff, err_in;
   logic [PROD_W-1:0]        plo_ff, plo_in;
   logic [PROD_W-1:0]        phi_ff, phi_in;
   logic                     mov_ff, reach_ff;

   logic [SUM_W-1:0]         dist_sum;
   logic [DIST_W-1:0]        dist_full;
   logic [SPEED_W-1:0]       dist_sat;
   logic [ERR_W-1:0]         abs_err;
   logic signed [ERR_W-1:0]  err_wrap;
   logic                     need_turn;
   logic                     load;

   logic                     rsp_valid_ff;
   logic [ACT_W-1:0]         action_ff, action_in;
   logic signed [HEAD_W-1:0] turn_ff, turn_in;
   logic [SPEED_W-1:0]       speed_ff, speed_in;

   // Bearing rounded to Q.16, heading error, and the two halves of the gain product.
   assign z_round = in_vec.z + ANG_W'(128);
   assign bearing = in_side.zero ? '0 : z_round[ANG_W-1:GUARD];
   assign err_in  = $signed({bearing[HEAD_W-1], bearing})
                    - $signed({in_side.heading[HEAD_W-1], in_side.heading});
   assign x_mag   = in_vec.x[2*SPLIT-1:0];
   assign plo_in  = x_mag[SPLIT-1:0] * INV_GAIN_Q30;
   assign phi_in  = x_mag[2*SPLIT-1:SPLIT] * INV_GAIN_Q30;

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= 1'b0;
      end else if (adv) begin
         v_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         err_ff   <= err_in;
         plo_ff   <= plo_in;
         phi_ff   <= phi_in;
         mov_ff   <= in_side.moving;
         reach_ff <= in_side.reached;
      end
   end

   // Distance: recombine, round, saturate.
   assign dist_sum  = {1'b0, phi_ff, {SPLIT{1'b0}}} + {{(SPLIT+1){1'b0}}, plo_ff} + DIST_ROUND;
   assign dist_full = dist_sum[SUM_W-1:DIST_SH];
   assign dist_sat  = (dist_full[DIST_W-1:SPEED_W] != '0) ? SPEED_MAX : dist_full[SPEED_W-1:0];

   // Heading error test and a single wrap by a full turn.
   assign abs_err   = err_ff[ERR_W-1] ? ERR_W'(-err_ff) : ERR_W'(err_ff);
   assign need_turn = abs_err > {{(ERR_W-HTOL_W){1'b0}}, heading_tol};

   always_comb begin
      if (err_ff > PI_Q16) begin
         err_wrap = err_ff - TWO_PI_Q16;
      end else if (err_ff < -PI_Q16) begin
         err_wrap = err_ff + TWO_PI_Q16;
      end else begin
         err_wrap = err_ff;
      end
   end

   // Priority decision.
   always_comb begin
      action_in = ACT_FORWARD;
      turn_in   = '0;
      speed_in  = '0;
      if (mov_ff) begin
         action_in = ACT_WAIT;
      end else if (reach_ff) begin
         action_in = ACT_REACHED;
      end else if (need_turn) begin
         action_in = ACT_TURN;
         turn_in   = err_wrap[HEAD_W-1:0];
      end else begin
         speed_in  = dist_sat;
      end
   end

   // Output register; it takes a new result once the current one has transferred.
   assign load = rsp_ready || !rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (load) begin
         rsp_valid_ff <= v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         action_ff <= action_in;
         turn_ff   <= turn_in;
         speed_ff  <= speed_in;
      end
   end

   assign stage_valid       = v_ff;
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_action        = action_ff;
   assign rsp_turn_rate     = turn_ff;
   assign rsp_forward_speed = speed_ff;

endmodule

`default_nettype wire

/* hdl/go_to_goal_turn_then_drive_unit.sv */
// A pose passes the front stages, the rotator and the back stages to its command.
// Throughput: one pose per cycle unless stalled; one rotator register stage per iteration.
// A stalled command holds the pipeline only when the stage ahead of the output is full.
// Reset (synchronous, active high) empties the pipeline and restores the goal and
// tolerance registers to their defaults; the register port is always ready.
`timescale 1ns / 1ps
`default_nettype none

module go_to_goal_turn_then_drive_unit import gtg_pkg::*; #(
   parameter int CORDIC_STAGES = 16
) (
   input  wire        clock,
   input  wire        reset,
   gtg_req_if.sink    req_bus,
   gtg_rsp_if.source  rsp_bus,
   gtg_csr_if.sink    csr_bus
);

   localparam int N_STAGES = (CORDIC_STAGES > ATAN_N) ? ATAN_N : CORDIC_STAGES;

   logic signed [COORD_W-1:0] goal_x_ff;
   logic signed [COORD_W-1:0] goal_y_ff;
   logic [HTOL_W-1:0]         htol_ff;
   logic [GTOL_W-1:0]         gtol_ff;

   logic     adv;
   logic     last_valid;
   logic     f_valid, c_valid;
   vec_type  f_vec, c_vec;
   side_type f_side, c_side;

   // Register writes.
   assign csr_bus.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         goal_x_ff <= '0;
         goal_y_ff <= '0;
         htol_ff   <= HTOL_RESET;
         gtol_ff   <= GTOL_RESET;
      end else if (csr_bus.valid) begin
         case (csr_bus.index)
            REG_GOAL_X:   goal_x_ff <= csr_bus.data;
            REG_GOAL_Y:   goal_y_ff <= csr_bus.data;
            REG_HEAD_TOL: htol_ff   <= csr_bus.data[HTOL_W-1:0];
            REG_GOAL_TOL: gtol_ff   <= csr_bus.data[GTOL_W-1:0];
            default: ;
         endcase
      end
   end

   // The pipeline moves unless the output holds a result and the stage ahead is full.
   assign adv           = rsp_bus.ready || !rsp_bus.valid || !last_valid;
   assign req_bus.ready = adv;

   gtg_front u_front (
      .clock            (clock),
      .reset            (reset),
      .adv              (adv),
      .in_valid         (req_bus.valid),
      .pose_x           (req_bus.pose_x),
      .pose_y           (req_bus.pose_y),
      .heading          (req_bus.heading),
      .lin_vel          (req_bus.lin_vel),
      .ang_vel          (req_bus.ang_vel),
      .goal_x           (goal_x_ff),
      .goal_y           (goal_y_ff),
      .goal_tol         (gtol_ff),
      .out_valid        (f_valid),
      .out_vec          (f_vec),
      .out_side         (f_side)
   );

   gtg_cordic #(
      .N_STAGES (N_STAGES)
   ) u_cordic (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (f_valid),
      .in_vec    (f_vec),
      .in_side   (f_side),
      .out_valid (c_valid),
      .out_vec   (c_vec),
      .out_side  (c_side)
   );

   gtg_back u_back (
      .clock             (clock),
      .reset             (reset),
      .adv               (adv),
      .in_valid          (c_valid),
      .in_vec            (c_vec),
      .in_side           (c_side),
      .heading_tol       (htol_ff),
      .rsp_ready         (rsp_bus.ready),
      .stage_valid       (last_valid),
      .rsp_valid         (rsp_bus.valid),
      .rsp_action        (rsp_bus.action),
      .rsp_turn_rate     (rsp_bus.turn_rate),
      .rsp_forward_speed (rsp_bus.forward_speed)
   );

endmodule

`default_nettype wire

/* hdl/gtg_checker.sv */
`timescale 1ns / 1ps
`default_nettype none

module gtg_checker import gtg_pkg::*; (
   input wire                      clock,
   input wire                      reset,
   input wire                      rsp_valid,
   input wire                      rsp_ready,
   input wire         [ACT_W-1:0]  rsp_action,
   input wire  signed [HEAD_W-1:0] rsp_turn_rate,
   input wire         [SPEED_W-1:0] rsp_forward_speed
);

   // Reset leaves no command on the output.
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("command offered straight after reset");

   // A command that is not taken stays as it is.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_action)
         && $stable(rsp_turn_rate) && $stable(rsp_forward_speed))
      else $error("command changed before its transfer");

   // Turn rate is only carried by a turn command.
   a_turn_only: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_action != ACT_TURN) |-> rsp_turn_rate == '0)
      else $error("turn rate set outside a turn command");

   // Speed is only carried by a forward command.
   a_speed_only: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_action != ACT_FORWARD) |-> rsp_forward_speed == '0)
      else $error("forward speed set outside a forward command");

endmodule

bind go_to_goal_turn_then_drive_unit gtg_checker u_gtg_checker (
   .clock             (clock),
   .reset             (reset),
   .rsp_valid         (rsp_bus.valid),
   .rsp_ready         (rsp_bus.ready),
   .rsp_action        (rsp_bus.action),
   .rsp_turn_rate     (rsp_bus.turn_rate),
   .rsp_forward_speed (rsp_bus.forward_speed)
);

`default_nettype wire

/* sim/tb_go_to_goal_turn_then_drive_unit.sv */
`timescale 1ns / 1ps

module tb_go_to_goal_turn_then_drive_unit;
   import gtg_pkg::*;

   localparam int CLK_PERIOD    = 8;
   localparam int CORDIC_STAGES = 16;
   localparam int ROT_STAGES    = (CORDIC_STAGES > 24) ? 24 : CORDIC_STAGES;
   localparam int PIPE_LATENCY  = ROT_STAGES + 4;
   localparam int LONG_HOLD     = 300;
   localparam int RUN_LIMIT_NS  = 2_000_000;

   localparam longint HALF_TURN_Q24 = 52707179;
   localparam longint HALF_TURN_Q16 = 205887;
   localparam longint FULL_TURN_Q16 = 411775;
   localparam longint unsigned RANGE_GAIN_Q30 = 64'd652032874;
   localparam longint unsigned RANGE_LIMIT    = 64'd16777215;

   typedef struct {
      logic signed [COORD_W-1:0] x;
      logic signed [COORD_W-1:0] y;
      logic signed [HEAD_W-1:0]  heading;
      logic signed [COORD_W-1:0] lin_vel;
      logic signed [COORD_W-1:0] ang_vel;
   } pose_sample_type;

   typedef struct {
      logic [ACT_W-1:0]         action;
      logic signed [HEAD_W-1:0] turn_rate;
      logic [SPEED_W-1:0]       forward_speed;
   } drive_cmd_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   gtg_req_if req_bus ();
   gtg_rsp_if rsp_bus ();
   gtg_csr_if csr_bus ();

   go_to_goal_turn_then_drive_unit #(
      .CORDIC_STAGES(CORDIC_STAGES)
   ) dut (
      .clock  (clock),
      .reset  (reset),
      .req_bus(req_bus),
      .rsp_bus(rsp_bus),
      .csr_bus(csr_bus)
   );

   pose_sample_type pose_pending_q [$];
   drive_cmd_type   cmd_expect_q [$];
   pose_sample_type pose_on_bus;
   int unsigned  poses_queued   = 0;
   int unsigned  poses_taken    = 0;
   int unsigned  mismatch_count = 0;
   int unsigned  req_idle_odds  = 6;
   int unsigned  rsp_idle_odds  = 6;
   int unsigned  req_gap        = 0;
   int unsigned  rsp_gap        = 0;
   int unsigned  hold_asked     = 0;
   int unsigned  hold_seen      = 0;

   // Shadow copy of the goal and tolerance registers.
   logic signed [COORD_W-1:0] goal_x_cfg   = '0;
   logic signed [COORD_W-1:0] goal_y_cfg   = '0;
   logic [HTOL_W-1:0]         head_tol_cfg = HTOL_RESET;
   logic [GTOL_W-1:0]         goal_tol_cfg = GTOL_RESET;

   // Arctangent of 2^-i in Q.24 radians, rounded to nearest.
   longint atan_tab [0:23] = '{
      13176795, 7778716, 4110060, 2086331, 1047214, 524117, 262123, 131069,
      65536, 32768, 16384, 8192, 4096, 2048, 1024, 512,
      256, 128, 64, 32, 16, 8, 4, 2
   };

   always #(CLK_PERIOD / 2) clock = ~clock;

   // Vectoring rotation: bearing in Q.16 radians and gain-corrected range in Q.16.
   function automatic void steer_vector(input longint ox, input longint oy,
                                        output longint bearing,
                                        output longint unsigned range);
      longint x, y, z, nx, ny;
      longint unsigned scaled;
      int i;
      bearing = 0;
      range   = 0;
      if (ox == 0 && oy == 0) return;
      z = 0;
      // The left half-plane is folded over, starting the angle at plus or minus pi.
      if (ox < 0) begin
         z  = (oy >= 0) ? HALF_TURN_Q24 : -HALF_TURN_Q24;
         ox = -ox;
         oy = -oy;
      end
      x = ox <<< 8;
      y = oy <<< 8;
      for (i = 0; i < ROT_STAGES; i++) begin
         if (y >= 0) begin
            nx = x + (y >>> i);
            ny = y - (x >>> i);
            z  = z + atan_tab[i];
         end else begin
            nx = x - (y >>> i);
            ny = y + (x >>> i);
            z  = z - atan_tab[i];
         end
         x = nx;
         y = ny;
      end
      bearing = (z + 128) >>> 8;
      scaled  = ($unsigned(x) * RANGE_GAIN_Q30 + (64'd1 << 37)) >> 38;
      range   = (scaled > RANGE_LIMIT) ? RANGE_LIMIT : scaled;
   endfunction

   // Works out the drive command owed for one pose sample under the current goal.
   function automatic drive_cmd_type predict_drive_cmd(pose_sample_type p);
      drive_cmd_type c;
      longint ox, oy, tol, bearing, err;
      longint unsigned range;
      c.action        = ACT_WAIT;
      c.turn_rate     = '0;
      c.forward_speed = '0;
      if (p.lin_vel != 0 || p.ang_vel != 0) return c;
      ox  = longint'(goal_x_cfg) - longint'(p.x);
      oy  = longint'(goal_y_cfg) - longint'(p.y);
      tol = longint'(goal_tol_cfg);
      if ((ox < 0 ? -ox : ox) < tol && (oy < 0 ? -oy : oy) < tol) begin
         c.action = ACT_REACHED;
         return c;
      end
      steer_vector(ox, oy, bearing, range);
      err = bearing - longint'(p.heading);
      if ((err < 0 ? -err : err) > longint'(head_tol_cfg)) begin
         // The heading error is wrapped once towards the half turn.
         if (err > HALF_TURN_Q16) begin
            err = err - FULL_TURN_Q16;
         end else if (err < -HALF_TURN_Q16) begin
            err = err + FULL_TURN_Q16;
         end
         c.action    = ACT_TURN;
         c.turn_rate = err[HEAD_W-1:0];
      end else begin
         c.action        = ACT_FORWARD;
         c.forward_speed = range[SPEED_W-1:0];
      end
      return c;
   endfunction

   function automatic pose_sample_type pose_of(longint x, longint y, longint hd,
                                               longint lv, longint av);
      pose_sample_type p;
      p.x       = x[COORD_W-1:0];
      p.y       = y[COORD_W-1:0];
      p.heading = hd[HEAD_W-1:0];
      p.lin_vel = lv[COORD_W-1:0];
      p.ang_vel = av[COORD_W-1:0];
      return p;
   endfunction

   function automatic logic signed [COORD_W-1:0] clamp_coord(longint v);
      if (v > 8388607) v = 8388607;
      else if (v < -8388608) v = -8388608;
      return v[COORD_W-1:0];
   endfunction

   // Points the heading at the goal, offset by the given jitter.
   function automatic pose_sample_type aimed(pose_sample_type p, longint jitter);
      longint bearing, v;
      longint unsigned range;
      steer_vector(longint'(goal_x_cfg) - longint'(p.x),
                   longint'(goal_y_cfg) - longint'(p.y), bearing, range);
      v = bearing + jitter;
      if (v > 524287) v = 524287;
      else if (v < -524288) v = -524288;
      p.heading = v[HEAD_W-1:0];
      return p;
   endfunction

   // Random pose: some moving, some near the goal, many aimed near the bearing.
   function automatic pose_sample_type random_pose();
      pose_sample_type p;
      int unsigned pick, shift;
      longint reach, ox, oy, jitter;
      pick = $urandom_range(0, 99);
      p    = pose_of($urandom, $urandom, $urandom, 0, 0);
      if (pick < 15) begin
         p.lin_vel = COORD_W'($urandom);
         p.ang_vel = COORD_W'($urandom);
         case ($urandom_range(0, 2))
            0: p.lin_vel = '0;
            1: p.ang_vel = '0;
            default: ;
         endcase
         if (p.lin_vel == 0 && p.ang_vel == 0) p.lin_vel = 1;
      end else if (pick < 35) begin
         reach = 2 * longint'(goal_tol_cfg) + 1;
         ox    = longint'($urandom_range(0, 2 * reach)) - reach;
         oy    = longint'($urandom_range(0, 2 * reach)) - reach;
         p.x   = clamp_coord(longint'(goal_x_cfg) - ox);
         p.y   = clamp_coord(longint'(goal_y_cfg) - oy);
      end else begin
         // Half of these sit at a random scale of distance from the goal.
         if ($urandom_range(0, 1) == 1) begin
            shift = $urandom_range(0, 23);
            ox    = longint'(p.x) >>> shift;
            oy    = longint'(p.y) >>> shift;
            p.x   = clamp_coord(longint'(goal_x_cfg) - ox);
            p.y   = clamp_coord(longint'(goal_y_cfg) - oy);
         end
         if (pick < 75) begin
            jitter = longint'($urandom_range(0, 2 * head_tol_cfg + 4))
                     - longint'(head_tol_cfg) - 2;
            p = aimed(p, jitter);
         end
      end
      return p;
   endfunction

   function automatic logic signed [COORD_W-1:0] random_goal();
      if ($urandom_range(0, 1) == 1) return COORD_W'($urandom);
      return clamp_coord(longint'($urandom_range(0, 1 << 21)) - (1 << 20));
   endfunction

   function automatic void queue_pose(pose_sample_type p);
      pose_pending_q.push_back(p);
      poses_queued++;
   endfunction

   task automatic report_mismatch(input string what);
      $display("%0d ns: mismatch, %s", $time, what);
      mismatch_count++;
   endtask

   // One register transfer; valid is left high for a following write.
   task automatic write_register(input logic [CSR_IDX_W-1:0] idx,
                                 input logic [CSR_DATA_W-1:0] value);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= idx;
      csr_bus.data  <= value;
      do @(posedge clock); while (!csr_bus.ready);
      case (idx)
         REG_GOAL_X:   goal_x_cfg   = value;
         REG_GOAL_Y:   goal_y_cfg   = value;
         REG_HEAD_TOL: head_tol_cfg = value[HTOL_W-1:0];
         REG_GOAL_TOL: goal_tol_cfg = value[GTOL_W-1:0];
         default: ;
      endcase
   endtask

   task automatic set_goal(input logic signed [COORD_W-1:0] gx,
                           input logic signed [COORD_W-1:0] gy,
                           input logic [HTOL_W-1:0] htol,
                           input logic [GTOL_W-1:0] gtol);
      write_register(REG_GOAL_X, gx);
      write_register(REG_GOAL_Y, gy);
      write_register(REG_HEAD_TOL, CSR_DATA_W'(htol));
      write_register(REG_GOAL_TOL, CSR_DATA_W'(gtol));
      csr_bus.valid <= 1'b0;
   endtask

   // Waits until every queued pose has been taken and every command has come back.
   task automatic wait_idle();
      do @(posedge clock); while (poses_taken != poses_queued || cmd_expect_q.size() != 0);
   endtask

   // Pose driver: offers queued samples, with random bursts of idling.
   always @(posedge clock) begin
      if (reset) begin
         req_bus.valid   <= 1'b0;
         req_bus.pose_x  <= '0;
         req_bus.pose_y  <= '0;
         req_bus.heading <= '0;
         req_bus.lin_vel <= '0;
         req_bus.ang_vel <= '0;
      end else begin
         // A transfer at this edge fixes the command that the block owes.
         if (req_bus.valid && req_bus.ready) begin
            cmd_expect_q.push_back(predict_drive_cmd(pose_on_bus));
            poses_taken++;
         end
         if (!req_bus.valid || req_bus.ready) begin
            if (req_gap != 0) begin
               req_gap--;
               req_bus.valid <= 1'b0;
            end else if (pose_pending_q.size() == 0) begin
               req_bus.valid <= 1'b0;
            end else if (req_idle_odds != 0 && $urandom_range(1, req_idle_odds) == 1) begin
               req_gap = $urandom_range(0, 16);
               req_bus.valid <= 1'b0;
            end else begin
               pose_on_bus = pose_pending_q.pop_front();
               req_bus.pose_x  <= pose_on_bus.x;
               req_bus.pose_y  <= pose_on_bus.y;
               req_bus.heading <= pose_on_bus.heading;
               req_bus.lin_vel <= pose_on_bus.lin_vel;
               req_bus.ang_vel <= pose_on_bus.ang_vel;
               req_bus.valid   <= 1'b1;
            end
         end
      end
   end

   // Command receiver: random stalls, and one long hold-off when requested.
   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else if (hold_seen != hold_asked) begin
         hold_seen = hold_asked;
         rsp_gap = LONG_HOLD - 1;
         rsp_bus.ready <= 1'b0;
      end else if (rsp_gap != 0) begin
         rsp_gap--;
         rsp_bus.ready <= 1'b0;
      end else if (rsp_idle_odds != 0 && $urandom_range(1, rsp_idle_odds) == 1) begin
         rsp_gap = $urandom_range(0, 16);
         rsp_bus.ready <= 1'b0;
      end else begin
         rsp_bus.ready <= 1'b1;
      end
   end

   // Command checker: each transfer is compared with the oldest expectation.
   always @(posedge clock) begin : cmd_check
      drive_cmd_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (cmd_expect_q.size() == 0) begin
            report_mismatch($sformatf("command with none pending, action %0d",
                                      rsp_bus.action));
         end else begin
            want = cmd_expect_q.pop_front();
            if (rsp_bus.action !== want.action)
               report_mismatch($sformatf("action %0d, wanted %0d",
                                         rsp_bus.action, want.action));
            if (rsp_bus.turn_rate !== want.turn_rate)
               report_mismatch($sformatf("turn_rate %0d, wanted %0d",
                                         rsp_bus.turn_rate, want.turn_rate));
            if (rsp_bus.forward_speed !== want.forward_speed)
               report_mismatch($sformatf("forward_speed %0d, wanted %0d",
                                         rsp_bus.forward_speed, want.forward_speed));
         end
      end
   end

   // Stimulus sequence.
   initial begin
      logic [HTOL_W-1:0] htol_pick;
      logic [GTOL_W-1:0] gtol_pick;
      int k, n;

      csr_bus.valid = 1'b0;
      csr_bus.index = REG_GOAL_X;
      csr_bus.data  = '0;

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Goal at the origin with the tolerances left at their reset values.
      queue_pose(pose_of(0, 0, 0, 1, 0));
      queue_pose(pose_of(0, 0, 0, 0, -1));
      queue_pose(pose_of(-8388608, 8388607, -524288, -8388608, 8388607));
      queue_pose(pose_of(0, 0, 0, 0, 0));
      queue_pose(pose_of(13106, -13106, 524287, 0, 0));
      queue_pose(aimed(pose_of(13107, 0, 0, 0, 0), 0));
      // Bearing close to a half turn against the opposite heading wraps both ways.
      queue_pose(pose_of(65536, -10, -205887, 0, 0));
      queue_pose(pose_of(65536, 10, 205887, 0, 0));
      queue_pose(pose_of(-65536, 0, -524288, 0, 0));
      queue_pose(pose_of(-65536, 0, 524287, 0, 0));
      queue_pose(pose_of(-65536, 0, 65536, 0, 0));
      // Heading error exactly at the tolerance drives; one step beyond turns.
      queue_pose(aimed(pose_of(-300000, 120000, 0, 0, 0), -3277));
      queue_pose(aimed(pose_of(-300000, 120000, 0, 0, 0), 3277));
      queue_pose(aimed(pose_of(-300000, 120000, 0, 0, 0), 3278));
      queue_pose(aimed(pose_of(8388607, -8388608, 0, 0, 0), 0));
      queue_pose(pose_of(-1, -1, -1, 0, 0));
      queue_pose(aimed(pose_of(0, -65536, 0, 0, 0), 0));
      queue_pose(aimed(pose_of(0, 65536, 0, 0, 0), 0));
      queue_pose(aimed(pose_of(-1, 0, 0, 0, 0), 0));
      wait_idle();

      // Far corner goal with zero tolerances: zero offset and a saturated range.
      set_goal(24'sh7FFFFF, 24'sh7FFFFF, '0, '0);
      queue_pose(pose_of(8388607, 8388607, 0, 0, 0));
      queue_pose(pose_of(8388607, 8388607, 1, 0, 0));
      queue_pose(aimed(pose_of(-8388608, -8388608, 0, 0, 0), 0));
      queue_pose(pose_of(8388607, 8388607, 0, 0, 1));
      for (n = 0; n < 70; n++) queue_pose(random_pose());
      wait_idle();

      // Opposite corner with the widest tolerances, under a long receiver hold-off.
      req_idle_odds = 8;
      rsp_idle_odds = 8;
      set_goal(24'sh800000, 24'sh800000, 19'h7FFFF, 23'h7FFFFF);
      hold_asked++;
      queue_pose(pose_of(-8388608, -8388608, 0, 0, 0));
      queue_pose(pose_of(8388607, 8388607, 524287, 0, 0));
      queue_pose(aimed(pose_of(8388607, 0, 0, 0, 0), 0));
      for (n = 0; n < 70; n++) queue_pose(random_pose());
      wait_idle();

      // Random goals and tolerances; the last phase runs without any idling.
      for (k = 0; k < 4; k++) begin
         case (k)
            0: begin req_idle_odds = 3;  rsp_idle_odds = 3;  end
            1: begin req_idle_odds = 12; rsp_idle_odds = 4;  end
            2: begin req_idle_odds = 4;  rsp_idle_odds = 12; end
            default: begin req_idle_odds = 0; rsp_idle_odds = 0; end
         endcase
         htol_pick = HTOL_W'(($urandom_range(0, 9) < 7) ? $urandom_range(0, 20000)
                                                         : $urandom);
         gtol_pick = GTOL_W'(($urandom_range(0, 9) < 7) ? $urandom_range(0, 200000)
                                                         : $urandom);
         set_goal(random_goal(), random_goal(), htol_pick, gtol_pick);
         for (n = 0; n < 80; n++) queue_pose(random_pose());
         wait_idle();
      end

      repeat (PIPE_LATENCY + 8) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

   // Watchdog against a hung handshake.
   initial begin
      #(RUN_LIMIT_NS);
      $display("[FAIL] regression broken");
      $finish;
   end

endmodule

/* filelist.f */
hdl/gtg_pkg.sv
hdl/gtg_if.sv
hdl/gtg_front.sv
hdl/gtg_cordic.sv
hdl/gtg_back.sv
hdl/go_to_goal_turn_then_drive_unit.sv
hdl/gtg_checker.sv
sim/tb_go_to_goal_turn_then_drive_unit.sv
